// ===== hw/rtl/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared widths, codes and helper functions for the learned colour classifier.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int CHAN_W     = 16;
    localparam int NUM_CH     = 3;
    localparam int CHROMA_W   = FRAC_BITS + 9;
    localparam int DVD_W      = CHAN_W + FRAC_BITS;
    localparam int CNT_W      = $clog2(DVD_W + 1);
    localparam int THR_W      = 17;
    localparam int SKIP_W     = 8;
    localparam int BOX_W      = (CHROMA_W > THR_W) ? CHROMA_W : THR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 8;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(2560);
    localparam logic [SKIP_W-1:0] SKIP_RESET      = SKIP_W'(4);

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SKIP      = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        CLASS_HOME  = 2'd0,
        CLASS_ARENA = 2'd1,
        CLASS_ENEMY = 2'd2
    } class_t;

    typedef enum logic [1:0] {
        PHASE_HOME     = 2'd0,
        PHASE_ARENA    = 2'd1,
        PHASE_CLASSIFY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIVIDE = 2'd1,
        ST_MATCH  = 2'd2,
        ST_DECIDE = 2'd3
    } state_t;

    // Clamp a full quotient to the largest chromaticity.
    function automatic logic [CHROMA_W-1:0] saturate(input logic [DVD_W-1:0] q);
        logic [CHROMA_W-1:0] r;
        if (q[DVD_W-1:CHROMA_W] != '0)
            r = '1;
        else
            r = q[CHROMA_W-1:0];
        return r;
    endfunction

    // Open box test on one channel: |x - r| < t.
    function automatic logic chan_near(input logic [CHROMA_W-1:0] x,
                                       input logic [CHROMA_W-1:0] r,
                                       input logic [THR_W-1:0]    t);
        logic [CHROMA_W:0]   d;
        logic [CHROMA_W:0]   mag;
        logic                hit;
        d   = {1'b0, x} - {1'b0, r};
        mag = d[CHROMA_W] ? (~d + 1'b1) : d;
        hit = (BOX_W'(mag[CHROMA_W-1:0]) < BOX_W'(t));
        return hit;
    endfunction

endpackage

// ===== hw/rtl/learned_colour_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// learned_colour_classifier_unit
// Surface classifier that learns a home and an arena colour reference.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one output transaction. A skipped
// tick is answered from the input cycle itself. A processed tick is accepted,
// passed through the three bit-serial restoring dividers that run side by
// side, tested against both references, and then used to update the phase
// and load the result once the output register is free. The input is
// accepted only while the unit is idle and the output register is free or
// being emptied. Register 0 is the match half-width, register 1 the number
// of skipped ticks.
module learned_colour_classifier_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // red_raw [15:0], green_raw [31:16], blue_raw [47:32], clear_raw [63:48]
    input  logic [lcc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // surface_class [1:0], sample_used [2], zero [7:3]
    output logic [lcc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               cfg_wr_en,
    input  logic [lcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Control state
    lcc_pkg::state_t                 state_reg, state_next;
    lcc_pkg::phase_t                 phase_reg, phase_next;
    lcc_pkg::class_t                 last_class_reg, last_class_next;
    logic [lcc_pkg::SKIP_W-1:0]      tick_reg, tick_next;
    logic [lcc_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            home_valid_reg, home_valid_next;
    logic                            arena_valid_reg, arena_valid_next;
    logic [lcc_pkg::THR_W-1:0]       thr_reg;
    logic [lcc_pkg::SKIP_W-1:0]      skip_reg;
    logic                            out_valid_reg, out_valid_next;

    // Payload
    logic [lcc_pkg::NUM_CH-1:0][lcc_pkg::CHAN_W-1:0]   rem_reg, rem_next;
    logic [lcc_pkg::NUM_CH-1:0][lcc_pkg::DVD_W-1:0]    quo_reg, quo_next;
    logic [lcc_pkg::CHAN_W-1:0]                        clear_reg, clear_next;
    logic [lcc_pkg::NUM_CH-1:0][lcc_pkg::CHROMA_W-1:0] home_ref_reg, home_ref_next;
    logic [lcc_pkg::NUM_CH-1:0][lcc_pkg::CHROMA_W-1:0] arena_ref_reg, arena_ref_next;
    logic                            home_hit_reg, home_hit_next;
    logic                            arena_hit_reg, arena_hit_next;
    lcc_pkg::class_t                 out_class_reg, out_class_next;
    logic                            out_used_reg, out_used_next;

    logic                            out_free;
    logic [lcc_pkg::NUM_CH-1:0][lcc_pkg::CHROMA_W-1:0] x;
    logic                            store_home;
    logic                            store_arena;
    logic                            home_hit_now;
    logic                            home_box;
    logic                            arena_box;
    logic [lcc_pkg::CHAN_W:0]        trial;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == lcc_pkg::ST_IDLE) && out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(lcc_pkg::OUT_DATA_W-3){1'b0}}, out_used_reg, out_class_reg};

    always_comb
    begin
        for (int c = 0; c < lcc_pkg::NUM_CH; c++)
        begin
            x[c] = lcc_pkg::saturate(quo_reg[c]);
        end
    end

    // A reference learned on this sample is the sample itself, so it matches
    // exactly when the threshold is nonzero.
    assign store_home   = (phase_reg == lcc_pkg::PHASE_HOME) && !home_valid_reg;
    assign home_hit_now = store_home ? (thr_reg != '0) : home_box;
    assign store_arena  = !arena_valid_reg &&
                          ((phase_reg == lcc_pkg::PHASE_ARENA) ||
                           ((phase_reg == lcc_pkg::PHASE_HOME) && !home_hit_now));

    always_comb
    begin
        home_box  = 1'b1;
        arena_box = 1'b1;
        for (int c = 0; c < lcc_pkg::NUM_CH; c++)
        begin
            home_box  = home_box  && lcc_pkg::chan_near(x[c], home_ref_reg[c], thr_reg);
            arena_box = arena_box && lcc_pkg::chan_near(x[c], arena_ref_reg[c], thr_reg);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        last_class_next  = last_class_reg;
        tick_next        = tick_reg;
        cnt_next         = cnt_reg;
        home_valid_next  = home_valid_reg;
        arena_valid_next = arena_valid_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        clear_next       = clear_reg;
        home_ref_next    = home_ref_reg;
        arena_ref_next   = arena_ref_reg;
        home_hit_next    = home_hit_reg;
        arena_hit_next   = arena_hit_reg;
        out_class_next   = out_class_reg;
        out_used_next    = out_used_reg;
        trial            = '0;

        case (state_reg)
            lcc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (tick_reg < skip_reg)
                    begin
                        tick_next      = tick_reg + 1'b1;
                        out_valid_next = 1'b1;
                        out_class_next = last_class_reg;
                        out_used_next  = 1'b0;
                    end
                    else
                    begin
                        tick_next  = '0;
                        cnt_next   = '0;
                        clear_next = s_axis_tdata[4*lcc_pkg::CHAN_W-1:3*lcc_pkg::CHAN_W];
                        for (int c = 0; c < lcc_pkg::NUM_CH; c++)
                        begin
                            rem_next[c] = '0;
                            quo_next[c] = {s_axis_tdata[c*lcc_pkg::CHAN_W +: lcc_pkg::CHAN_W],
                                           {lcc_pkg::FRAC_BITS{1'b0}}};
                        end
                        state_next = lcc_pkg::ST_DIVIDE;
                    end
                end
            end

            lcc_pkg::ST_DIVIDE:
            begin
                // One quotient bit per lane per cycle; dividend bits leave the
                // top of quo_reg while quotient bits enter at the bottom.
                for (int c = 0; c < lcc_pkg::NUM_CH; c++)
                begin
                    trial = {rem_reg[c], quo_reg[c][lcc_pkg::DVD_W-1]};
                    if (trial >= {1'b0, clear_reg})
                    begin
                        rem_next[c] = lcc_pkg::CHAN_W'(trial - {1'b0, clear_reg});
                        quo_next[c] = {quo_reg[c][lcc_pkg::DVD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[c] = trial[lcc_pkg::CHAN_W-1:0];
                        quo_next[c] = {quo_reg[c][lcc_pkg::DVD_W-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lcc_pkg::CNT_W'(lcc_pkg::DVD_W - 1))
                begin
                    state_next = lcc_pkg::ST_MATCH;
                end
            end

            lcc_pkg::ST_MATCH:
            begin
                home_hit_next = home_hit_now;
                if (store_home)
                begin
                    home_ref_next   = x;
                    home_valid_next = 1'b1;
                end
                arena_hit_next = store_arena ? (thr_reg != '0) : arena_box;
                if (store_arena)
                begin
                    arena_ref_next   = x;
                    arena_valid_next = 1'b1;
                end
                state_next = lcc_pkg::ST_DECIDE;
            end

            lcc_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    case (phase_reg)
                        lcc_pkg::PHASE_HOME:
                        begin
                            if (home_hit_reg)
                                last_class_next = lcc_pkg::CLASS_HOME;
                            else if (arena_hit_reg)
                            begin
                                last_class_next = lcc_pkg::CLASS_ARENA;
                                phase_next      = lcc_pkg::PHASE_ARENA;
                            end
                            else
                            begin
                                last_class_next = lcc_pkg::CLASS_ENEMY;
                                phase_next      = lcc_pkg::PHASE_CLASSIFY;
                            end
                        end
                        lcc_pkg::PHASE_ARENA:
                        begin
                            if (arena_hit_reg)
                                last_class_next = lcc_pkg::CLASS_ARENA;
                            else
                            begin
                                phase_next      = lcc_pkg::PHASE_CLASSIFY;
                                last_class_next = home_hit_reg ? lcc_pkg::CLASS_HOME
                                                               : lcc_pkg::CLASS_ENEMY;
                            end
                        end
                        default:
                        begin
                            if (home_hit_reg)
                                last_class_next = lcc_pkg::CLASS_HOME;
                            else if (arena_hit_reg)
                                last_class_next = lcc_pkg::CLASS_ARENA;
                            else
                                last_class_next = lcc_pkg::CLASS_ENEMY;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    out_class_next = last_class_next;
                    out_used_next  = 1'b1;
                    state_next     = lcc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lcc_pkg::ST_IDLE;
            phase_reg       <= lcc_pkg::PHASE_HOME;
            last_class_reg  <= lcc_pkg::CLASS_HOME;
            tick_reg        <= '0;
            cnt_reg         <= '0;
            home_valid_reg  <= 1'b0;
            arena_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            last_class_reg  <= last_class_next;
            tick_reg        <= tick_next;
            cnt_reg         <= cnt_next;
            home_valid_reg  <= home_valid_next;
            arena_valid_reg <= arena_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= lcc_pkg::THRESHOLD_RESET;
            skip_reg <= lcc_pkg::SKIP_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lcc_pkg::REG_THRESHOLD: thr_reg  <= cfg_data[lcc_pkg::THR_W-1:0];
                lcc_pkg::REG_SKIP:      skip_reg <= cfg_data[lcc_pkg::SKIP_W-1:0];
                default:                thr_reg  <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        clear_reg     <= clear_next;
        home_ref_reg  <= home_ref_next;
        arena_ref_reg <= arena_ref_next;
        home_hit_reg  <= home_hit_next;
        arena_hit_reg <= arena_hit_next;
        out_class_reg <= out_class_next;
        out_used_reg  <= out_used_next;
    end

endmodule
